// ----- rtl/lmlt_pkg.sv -----
package lmlt_pkg;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    localparam logic [1:0] PHASE_ENTRY   = 2'd0;
    localparam logic [1:0] PHASE_WAIT    = 2'd1;
    localparam logic [1:0] PHASE_ADVANCE = 2'd2;

    localparam logic [9:0] SEARCH_CHUNK = 10'd8;
    localparam logic [6:0] SEARCH_TOTAL = 7'd80;
    localparam logic [9:0] DRAW_DOTS    = 10'd289;
    localparam logic [9:0] HBLANK_DOTS  = 10'd87;
    localparam logic [9:0] VLINE_DOTS   = 10'd456;

    localparam logic [7:0] LAST_VISIBLE = 8'd143;
    localparam logic [7:0] LAST_LINE    = 8'd153;

    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } lmlt_cmd_t;

    typedef struct packed {
        logic halt;
    } lmlt_status_t;

endpackage

// ----- rtl/lmlt_if.sv -----
interface lmlt_in_if;
    logic       valid;
    logic       ready;
    logic [5:0] machine_cycles;
    logic       lcd_on;
    logic [7:0] compare_line;
    logic       hblank_irq_en;
    logic       vblank_irq_en;
    logic       search_irq_en;
    logic       match_irq_en;

    modport source (
        output valid, machine_cycles, lcd_on, compare_line,
               hblank_irq_en, vblank_irq_en, search_irq_en, match_irq_en,
        input  ready
    );
    modport sink (
        input  valid, machine_cycles, lcd_on, compare_line,
               hblank_irq_en, vblank_irq_en, search_irq_en, match_irq_en,
        output ready
    );
endinterface

interface lmlt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status_mode;
    logic [7:0] line;
    logic       coincidence;
    logic       stat_irq;
    logic       vblank_irq;
    logic       frame_done;

    modport source (
        output valid, status_mode, line, coincidence, stat_irq, vblank_irq, frame_done,
        input  ready
    );
    modport sink (
        input  valid, status_mode, line, coincidence, stat_irq, vblank_irq, frame_done,
        output ready
    );
endinterface

// ----- rtl/lmlt_ctrl.sv -----
module lmlt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lmlt_pkg::lmlt_cmd_t    cmd,
    input  lmlt_pkg::lmlt_status_t status
);
    import lmlt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.halt)
                begin
                    // The result register frees up in the same cycle it is taken.
                    if (!out_valid_reg || out_ready)
                    begin
                        cmd.capture    = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_ready)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/lmlt_datapath.sv -----
module lmlt_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lmlt_pkg::lmlt_cmd_t    cmd,
    output lmlt_pkg::lmlt_status_t status,
    input  logic [5:0]             machine_cycles,
    input  logic                   lcd_on,
    input  logic [7:0]             compare_line,
    input  logic                   hblank_irq_en,
    input  logic                   vblank_irq_en,
    input  logic                   search_irq_en,
    input  logic                   match_irq_en,
    output logic [1:0]             status_mode,
    output logic [7:0]             line,
    output logic                   coincidence,
    output logic                   stat_irq,
    output logic                   vblank_irq,
    output logic                   frame_done
);
    import lmlt_pkg::*;

    logic [7:0] line_reg,   line_next;
    logic [1:0] mode_reg,   mode_next;
    logic [9:0] pool_reg,   pool_next;
    logic [8:0] need_reg,   need_next;
    logic [1:0] phase_reg,  phase_next;
    logic [6:0] sdots_reg,  sdots_next;
    logic       match_reg,  match_next;
    logic       on_reg,     on_next;
    logic [7:0] cmp_reg;
    logic       hb_en_reg, vb_en_reg, se_en_reg, mt_en_reg;
    logic [1:0] entry_reg,  entry_next;
    logic       stat_reg,   stat_next;
    logic       vbl_reg,    vbl_next;
    logic       frame_reg,  frame_next;
    logic [1:0] out_mode_reg;
    logic [7:0] out_line_reg;
    logic       out_match_reg, out_stat_reg, out_vbl_reg, out_frame_reg;

    logic       covered;
    logic       brk;
    logic       enter;
    logic [7:0] enter_val;
    logic [6:0] sdots_sum;

    assign covered   = (pool_reg >= {1'b0, need_reg});
    assign sdots_sum = sdots_reg + SEARCH_CHUNK[6:0];

    always_comb
    begin
        line_next  = line_reg;
        mode_next  = mode_reg;
        pool_next  = pool_reg;
        need_next  = need_reg;
        phase_next = phase_reg;
        sdots_next = sdots_reg;
        match_next = match_reg;
        on_next    = on_reg;
        entry_next = entry_reg;
        stat_next  = stat_reg;
        vbl_next   = vbl_reg;
        frame_next = frame_reg;
        brk        = 1'b0;
        enter      = 1'b0;
        enter_val  = line_reg + 8'd1;

        if (cmd.load)
        begin
            on_next    = lcd_on;
            entry_next = lcd_on ? mode_reg : MODE_SEARCH;
            stat_next  = 1'b0;
            vbl_next   = 1'b0;
            frame_next = 1'b0;
            if (!lcd_on)
            begin
                line_next  = '0;
                mode_next  = MODE_SEARCH;
                pool_next  = '0;
                need_next  = '0;
                phase_next = PHASE_ENTRY;
                sdots_next = '0;
                match_next = 1'b0;
            end
            else
            begin
                pool_next = pool_reg + {2'b00, machine_cycles, 2'b00};
            end
        end
        else if (cmd.step && on_reg && covered)
        begin
            case (mode_reg)
                MODE_HBLANK:
                begin
                    if (phase_reg == PHASE_ENTRY)
                    begin
                        stat_next  = stat_reg | hb_en_reg;
                        phase_next = PHASE_WAIT;
                    end
                    else if (pool_reg < HBLANK_DOTS)
                    begin
                        need_next = HBLANK_DOTS[8:0];
                        brk       = 1'b1;
                    end
                    else
                    begin
                        pool_next  = pool_reg - HBLANK_DOTS;
                        need_next  = '0;
                        enter      = 1'b1;
                        phase_next = PHASE_ENTRY;
                        if (line_reg == LAST_VISIBLE)
                        begin
                            mode_next  = MODE_VBLANK;
                            frame_next = 1'b1;
                        end
                        else
                        begin
                            mode_next = MODE_SEARCH;
                        end
                    end
                end
                MODE_VBLANK:
                begin
                    if (phase_reg == PHASE_ENTRY)
                    begin
                        vbl_next   = 1'b1;
                        stat_next  = stat_reg | vb_en_reg;
                        phase_next = PHASE_WAIT;
                    end
                    else if (phase_reg == PHASE_WAIT)
                    begin
                        if (pool_reg < VLINE_DOTS)
                        begin
                            need_next = VLINE_DOTS[8:0];
                            brk       = 1'b1;
                        end
                        else
                        begin
                            pool_next  = pool_reg - VLINE_DOTS;
                            need_next  = '0;
                            phase_next = PHASE_ADVANCE;
                        end
                    end
                    else
                    begin
                        enter = 1'b1;
                        if (line_reg == LAST_LINE)
                        begin
                            mode_next  = MODE_SEARCH;
                            enter_val  = '0;
                            phase_next = PHASE_ENTRY;
                        end
                        else
                        begin
                            phase_next = PHASE_WAIT;
                        end
                    end
                end
                MODE_SEARCH:
                begin
                    if (phase_reg == PHASE_ENTRY)
                    begin
                        stat_next  = stat_reg | se_en_reg;
                        phase_next = PHASE_WAIT;
                    end
                    else if (pool_reg < SEARCH_CHUNK)
                    begin
                        need_next = SEARCH_CHUNK[8:0];
                        brk       = 1'b1;
                    end
                    else
                    begin
                        pool_next = pool_reg - SEARCH_CHUNK;
                        if (sdots_sum >= SEARCH_TOTAL)
                        begin
                            mode_next  = MODE_DRAW;
                            need_next  = '0;
                            phase_next = PHASE_ENTRY;
                            sdots_next = '0;
                        end
                        else
                        begin
                            sdots_next = sdots_sum;
                            need_next  = SEARCH_CHUNK[8:0];
                        end
                    end
                end
                default:
                begin
                    if (phase_reg == PHASE_ENTRY)
                    begin
                        phase_next = PHASE_WAIT;
                    end
                    else if (pool_reg < DRAW_DOTS)
                    begin
                        need_next = DRAW_DOTS[8:0];
                        brk       = 1'b1;
                    end
                    else
                    begin
                        pool_next  = pool_reg - DRAW_DOTS;
                        need_next  = '0;
                        mode_next  = MODE_HBLANK;
                        phase_next = PHASE_ENTRY;
                    end
                end
            endcase

            // Every line change compares the new line with the compare value.
            if (enter)
            begin
                line_next  = enter_val;
                match_next = (enter_val == cmp_reg);
                if ((enter_val == cmp_reg) && mt_en_reg)
                begin
                    stat_next = 1'b1;
                end
            end
        end
    end

    assign status.halt = !on_reg || !covered || brk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg  <= '0;
            mode_reg  <= MODE_SEARCH;
            pool_reg  <= '0;
            need_reg  <= '0;
            phase_reg <= PHASE_ENTRY;
            sdots_reg <= '0;
            match_reg <= 1'b0;
            on_reg    <= 1'b0;
        end
        else
        begin
            line_reg  <= line_next;
            mode_reg  <= mode_next;
            pool_reg  <= pool_next;
            need_reg  <= need_next;
            phase_reg <= phase_next;
            sdots_reg <= sdots_next;
            match_reg <= match_next;
            on_reg    <= on_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        stat_reg  <= stat_next;
        vbl_reg   <= vbl_next;
        frame_reg <= frame_next;
        if (cmd.load)
        begin
            cmp_reg   <= compare_line;
            hb_en_reg <= hblank_irq_en;
            vb_en_reg <= vblank_irq_en;
            se_en_reg <= search_irq_en;
            mt_en_reg <= match_irq_en;
        end
        if (cmd.capture)
        begin
            out_mode_reg  <= entry_reg;
            out_line_reg  <= line_reg;
            out_match_reg <= match_reg;
            out_stat_reg  <= stat_reg;
            out_vbl_reg   <= vbl_reg;
            out_frame_reg <= frame_reg;
        end
    end

    assign status_mode = out_mode_reg;
    assign line        = out_line_reg;
    assign coincidence = out_match_reg;
    assign stat_irq    = out_stat_reg;
    assign vblank_irq  = out_vbl_reg;
    assign frame_done  = out_frame_reg;

endmodule

// ----- rtl/lcd_mode_line_timing.sv -----
// LCD mode and line timing.
// The item channel takes one request per CPU step: elapsed machine cycles
// (four dots each), the display enable, the compare line and four status
// interrupt enables. The result channel returns one item per request: the
// mode at entry, the line after the step, the coincidence flag and the stat,
// vblank and frame pulses gathered during the step.
// A request is taken only while the sequencer is idle. It then applies one
// mode phase per clock while the dot pool covers the current need; the
// phase steps that a request crosses are usually 0 to 4, more while object
// search eats 8-dot chunks. The result is registered after the last step.
// A stalled result sits in the output register while the next request is
// taken and processed; the sequencer waits before its own result only if
// the previous one has still not been taken.
// Reset puts the block at line 0 in object search with an empty dot pool
// and no pending result. A display-off request resets line, mode and pool.
module lcd_mode_line_timing (
    input logic        clk,
    input logic        rst_n,
    lmlt_in_if.sink    item,
    lmlt_out_if.source result
);
    import lmlt_pkg::*;

    lmlt_cmd_t    cmd;
    lmlt_status_t status;

    lmlt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .status    (status)
    );

    lmlt_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .machine_cycles (item.machine_cycles),
        .lcd_on         (item.lcd_on),
        .compare_line   (item.compare_line),
        .hblank_irq_en  (item.hblank_irq_en),
        .vblank_irq_en  (item.vblank_irq_en),
        .search_irq_en  (item.search_irq_en),
        .match_irq_en   (item.match_irq_en),
        .status_mode    (result.status_mode),
        .line           (result.line),
        .coincidence    (result.coincidence),
        .stat_irq       (result.stat_irq),
        .vblank_irq     (result.vblank_irq),
        .frame_done     (result.frame_done)
    );

endmodule

// ----- rtl/lmlt_checker.sv -----
module lmlt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] line,
    input logic       vblank_irq,
    input logic       frame_done
);
    import lmlt_pkg::*;

    // A result held back by the receiver is not withdrawn.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // The sequencer works on one request at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while the previous one is in progress");

    // Finishing the last visible line always enters vertical blank.
    a_frame_vblank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> vblank_irq && (line > LAST_VISIBLE))
        else $error("frame pulse without vertical blank entry");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> line <= LAST_LINE)
        else $error("line beyond the last line");

endmodule

bind lcd_mode_line_timing lmlt_checker u_lmlt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .line       (result.line),
    .vblank_irq (result.vblank_irq),
    .frame_done (result.frame_done)
);

// ----- tb/sv/lcd_timing_checker.sv -----
module lcd_timing_checker (
    input  logic clk,
    input  logic rst_n,
    lmlt_in_if   req_if,
    lmlt_out_if  res_if,
    output int   mismatches,
    output int   outstanding
);
    import lmlt_pkg::*;

    typedef struct packed {
        logic [5:0] machine_cycles;
        logic       lcd_on;
        logic [7:0] compare_line;
        logic       hblank_irq_en;
        logic       vblank_irq_en;
        logic       search_irq_en;
        logic       match_irq_en;
    } lcd_req_t;

    typedef struct packed {
        logic [1:0] status_mode;
        logic [7:0] line;
        logic       coincidence;
        logic       stat_irq;
        logic       vblank_irq;
        logic       frame_done;
    } line_status_t;

    // Shadow copy of the timing state.
    logic [7:0] line_q;
    logic [1:0] mode_q;
    logic [1:0] phase_q;
    logic [9:0] pool_q;
    logic [8:0] need_q;
    logic [6:0] search_acc;
    logic       match_q;

    line_status_t line_status_q[$];

    function automatic void clear_timing();
        line_q     = 8'd0;
        mode_q     = MODE_SEARCH;
        phase_q    = PHASE_ENTRY;
        pool_q     = 10'd0;
        need_q     = 9'd0;
        search_acc = 7'd0;
        match_q    = 1'b0;
    endfunction

    // Adds the elapsed dots and walks the mode phases while the pool covers
    // the current need, collecting the pulses raised along the way.
    function automatic line_status_t advance_dots(input lcd_req_t r);
        line_status_t res;
        logic         waiting;
        logic         moved;
        logic [7:0]   next_line;
        res = '0;
        if (!r.lcd_on)
        begin
            clear_timing();
            res.status_mode = MODE_SEARCH;
        end
        else
        begin
            res.status_mode = mode_q;
            pool_q = pool_q + {2'b00, r.machine_cycles, 2'b00};
            waiting = 1'b0;
            while (!waiting && pool_q >= {1'b0, need_q})
            begin
                moved = 1'b0;
                next_line = line_q + 8'd1;
                case (mode_q)
                    MODE_HBLANK:
                    begin
                        if (phase_q == PHASE_ENTRY)
                        begin
                            if (r.hblank_irq_en)
                                res.stat_irq = 1'b1;
                            phase_q = PHASE_WAIT;
                        end
                        else if (pool_q < HBLANK_DOTS)
                        begin
                            need_q = HBLANK_DOTS[8:0];
                            waiting = 1'b1;
                        end
                        else
                        begin
                            pool_q = pool_q - HBLANK_DOTS;
                            need_q = 9'd0;
                            moved = 1'b1;
                            phase_q = PHASE_ENTRY;
                            if (line_q == LAST_VISIBLE)
                            begin
                                mode_q = MODE_VBLANK;
                                res.frame_done = 1'b1;
                            end
                            else
                            begin
                                mode_q = MODE_SEARCH;
                            end
                        end
                    end
                    MODE_VBLANK:
                    begin
                        if (phase_q == PHASE_ENTRY)
                        begin
                            res.vblank_irq = 1'b1;
                            if (r.vblank_irq_en)
                                res.stat_irq = 1'b1;
                            phase_q = PHASE_WAIT;
                        end
                        else if (phase_q == PHASE_WAIT)
                        begin
                            if (pool_q < VLINE_DOTS)
                            begin
                                need_q = VLINE_DOTS[8:0];
                                waiting = 1'b1;
                            end
                            else
                            begin
                                pool_q = pool_q - VLINE_DOTS;
                                need_q = 9'd0;
                                phase_q = PHASE_ADVANCE;
                            end
                        end
                        else
                        begin
                            moved = 1'b1;
                            if (line_q == LAST_LINE)
                            begin
                                mode_q = MODE_SEARCH;
                                next_line = 8'd0;
                                phase_q = PHASE_ENTRY;
                            end
                            else
                            begin
                                phase_q = PHASE_WAIT;
                            end
                        end
                    end
                    MODE_SEARCH:
                    begin
                        if (phase_q == PHASE_ENTRY)
                        begin
                            if (r.search_irq_en)
                                res.stat_irq = 1'b1;
                            phase_q = PHASE_WAIT;
                        end
                        else if (pool_q < SEARCH_CHUNK)
                        begin
                            need_q = SEARCH_CHUNK[8:0];
                            waiting = 1'b1;
                        end
                        else
                        begin
                            pool_q = pool_q - SEARCH_CHUNK;
                            search_acc = search_acc + SEARCH_CHUNK[6:0];
                            if (search_acc >= SEARCH_TOTAL)
                            begin
                                mode_q = MODE_DRAW;
                                need_q = 9'd0;
                                phase_q = PHASE_ENTRY;
                                search_acc = 7'd0;
                            end
                            else
                            begin
                                need_q = SEARCH_CHUNK[8:0];
                            end
                        end
                    end
                    default:
                    begin
                        if (phase_q == PHASE_ENTRY)
                        begin
                            phase_q = PHASE_WAIT;
                        end
                        else if (pool_q < DRAW_DOTS)
                        begin
                            need_q = DRAW_DOTS[8:0];
                            waiting = 1'b1;
                        end
                        else
                        begin
                            pool_q = pool_q - DRAW_DOTS;
                            need_q = 9'd0;
                            mode_q = MODE_HBLANK;
                            phase_q = PHASE_ENTRY;
                        end
                    end
                endcase
                // The compare line is checked only when the line changes.
                if (moved)
                begin
                    line_q = next_line;
                    match_q = (line_q == r.compare_line);
                    if (match_q && r.match_irq_en)
                        res.stat_irq = 1'b1;
                end
            end
        end
        res.line = line_q;
        res.coincidence = match_q;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        line_status_t want;
        line_status_t got;
        lcd_req_t     req;
        if (!rst_n)
        begin
            clear_timing();
            line_status_q.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                got.status_mode = res_if.status_mode;
                got.line        = res_if.line;
                got.coincidence = res_if.coincidence;
                got.stat_irq    = res_if.stat_irq;
                got.vblank_irq  = res_if.vblank_irq;
                got.frame_done  = res_if.frame_done;
                if (line_status_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with no request pending: mode %0d line %0d",
                                 got.status_mode, got.line);
                end
                else
                begin
                    want = line_status_q.pop_front();
                    if (got.status_mode !== want.status_mode || got.line !== want.line ||
                        got.coincidence !== want.coincidence ||
                        got.stat_irq !== want.stat_irq ||
                        got.vblank_irq !== want.vblank_irq ||
                        got.frame_done !== want.frame_done)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("line status mismatch: expected mode %0d line %0d ",
                                   want.status_mode, want.line);
                            $write("coin %b stat %b vbl %b frame %b, ",
                                   want.coincidence, want.stat_irq, want.vblank_irq,
                                   want.frame_done);
                            $display("got mode %0d line %0d coin %b stat %b vbl %b frame %b",
                                     got.status_mode, got.line, got.coincidence,
                                     got.stat_irq, got.vblank_irq, got.frame_done);
                        end
                    end
                end
            end
            if (req_if.valid && req_if.ready)
            begin
                req.machine_cycles = req_if.machine_cycles;
                req.lcd_on         = req_if.lcd_on;
                req.compare_line   = req_if.compare_line;
                req.hblank_irq_en  = req_if.hblank_irq_en;
                req.vblank_irq_en  = req_if.vblank_irq_en;
                req.search_irq_en  = req_if.search_irq_en;
                req.match_irq_en   = req_if.match_irq_en;
                line_status_q.push_back(advance_dots(req));
            end
            outstanding = line_status_q.size();
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    logic quiet;
    logic [7:0] seen_line;
    logic [7:0] cmp_sel;

    lmlt_in_if  req_ch ();
    lmlt_out_if res_ch ();

    lcd_mode_line_timing u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (req_ch),
        .result (res_ch)
    );

    lcd_timing_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_if      (req_ch),
        .res_if      (res_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The line last reported lets the compare value land near real lines.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_line <= 8'd0;
        else if (res_ch.valid && res_ch.ready)
            seen_line <= res_ch.line;
    end

    // Receiver: runs of ready and stall, mostly short, a few long.
    initial
    begin
        int hold;
        int pick;
        hold = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
            end
            else
            begin
                pick = $urandom_range(0, 19);
                if (pick < 12)
                begin
                    res_ch.ready <= 1'b1;
                    hold = $urandom_range(1, 8);
                end
                else if (pick < 13)
                begin
                    res_ch.ready <= 1'b1;
                    hold = $urandom_range(100, 200);
                end
                else if (pick < 19)
                begin
                    res_ch.ready <= 1'b0;
                    hold = $urandom_range(1, 3);
                end
                else
                begin
                    res_ch.ready <= 1'b0;
                    hold = $urandom_range(15, 60);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Holds the request until it is taken, then leaves a random gap.
    task automatic issue(input logic [5:0] cyc, input logic on, input logic [7:0] cmp,
                         input logic [3:0] en);
        int gap;
        int pick;
        req_ch.valid          <= 1'b1;
        req_ch.machine_cycles <= cyc;
        req_ch.lcd_on         <= on;
        req_ch.compare_line   <= cmp;
        req_ch.hblank_irq_en  <= en[3];
        req_ch.vblank_irq_en  <= en[2];
        req_ch.search_irq_en  <= en[1];
        req_ch.match_irq_en   <= en[0];
        do
            @(posedge clk);
        while (!req_ch.ready);
        pick = $urandom_range(0, 99);
        if (quiet || pick < 50)
            gap = 0;
        else if (pick < 95)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(15, 60);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [5:0] cyc;
        logic       on;
        int         pick;
        quiet = 1'b0;
        cmp_sel = 8'd0;
        rst_n = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.machine_cycles = 6'd0;
        req_ch.lcd_on         = 1'b0;
        req_ch.compare_line   = 8'd0;
        req_ch.hblank_irq_en  = 1'b0;
        req_ch.vblank_irq_en  = 1'b0;
        req_ch.search_irq_en  = 1'b0;
        req_ch.match_irq_en   = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Display off first, then a zero-cycle step on line 0, which is not
        // compared until the line changes.
        issue(6'd63, 1'b0, 8'd255, 4'hF);
        issue(6'd0, 1'b1, 8'd0, 4'hF);
        issue(6'd1, 1'b1, 8'd0, 4'hF);
        issue(6'd1, 1'b1, 8'd0, 4'hF);
        // Full steps through search, drawing and horizontal blank into the following lines.
        issue(6'd63, 1'b1, 8'd1, 4'hF);
        issue(6'd63, 1'b1, 8'd1, 4'hF);
        issue(6'd63, 1'b1, 8'd1, 4'hF);
        issue(6'd63, 1'b1, 8'd1, 4'h0);
        issue(6'd63, 1'b1, 8'd2, 4'h1);
        issue(6'd63, 1'b1, 8'd2, 4'h1);
        issue(6'd63, 1'b1, 8'd2, 4'h1);
        issue(6'd2, 1'b1, 8'd255, 4'h8);
        issue(6'd0, 1'b1, 8'd255, 4'h0);
        // Display off in the middle of a line, then restart.
        issue(6'd63, 1'b0, 8'd0, 4'hF);
        issue(6'd63, 1'b1, 8'd0, 4'h2);
        issue(6'd63, 1'b1, 8'd0, 4'h2);
        issue(6'd63, 1'b1, 8'd0, 4'h2);
        issue(6'd63, 1'b1, 8'd0, 4'h2);
        issue(6'd31, 1'b1, 8'd128, 4'h5);
        issue(6'd32, 1'b1, 8'd127, 4'hA);

        // Mostly enabled display with large steps so that whole frames,
        // vertical blank and the wrap to line 0 are reached.
        for (int n = 0; n < 2000; n++)
        begin
            if (n % 150 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (n == 1000)
            begin
                req_ch.valid <= 1'b0;
                @(negedge clk);
                while (outstanding != 0)
                    @(negedge clk);
                @(posedge clk);
            end
            on = ($urandom_range(0, 399) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 6)
                cyc = 6'($urandom_range(0, 63));
            else if (pick < 9)
                cyc = 6'($urandom_range(40, 63));
            else
                cyc = 6'($urandom_range(0, 3));
            pick = $urandom_range(0, 9);
            if (pick < 5)
                cmp_sel = seen_line + 8'($urandom_range(0, 2));
            else if (pick == 5)
                cmp_sel = 8'($urandom_range(0, 255));
            issue(cyc, on, cmp_sel, 4'($urandom_range(0, 15)));
        end

        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
